// File: hdl/affine_from_three_point_pairs_unit_defines.svh
// Assertion macros for the affine-from-three-point-pairs unit.
// Depends on nothing; included by the top level.
`ifndef AFFINE_FROM_THREE_POINT_PAIRS_UNIT_DEFINES_SVH
`define AFFINE_FROM_THREE_POINT_PAIRS_UNIT_DEFINES_SVH
// Asserts that a condition implies a second one in the same cycle.
`define AFTP_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
// Asserts that a condition implies a second one in the next cycle.
`define AFTP_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

// File: hdl/aftp_pkg.sv
// Shared constants and types for the affine-from-three-point-pairs unit.
// Depends on nothing.
package aftp_pkg;
   localparam int COORD_BITS = 15;
   localparam int FRAC_BITS = 16;
   localparam int IN_COORD_BITS = 15;
   localparam int SHIFT_BITS = 16;
   localparam int OUT_BITS = 48;
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int DET_BITS = 2 * DIFF_BITS + 1;
   localparam int U_BITS = SHIFT_BITS + 2 > COORD_BITS + 2 ? SHIFT_BITS + 2 : COORD_BITS + 2;
   localparam int G_BITS = U_BITS + 1;
   localparam int NUM_BITS = G_BITS + DIFF_BITS + 1;
   localparam int CON_BITS = U_BITS + DET_BITS + 3;
   localparam int QUO_BITS = OUT_BITS + 2;
   localparam int DIV_STEPS = CON_BITS + FRAC_BITS;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int NUM_COEF = 6;

   typedef struct packed {
      logic signed [DET_BITS-1:0] det;
      logic signed [NUM_COEF-1:0][CON_BITS-1:0] num;
   } job_type;
endpackage

// File: hdl/affine_from_three_point_pairs_unit.sv
// Affine coefficients from three corner/displacement pairs. One item can be
// accepted every cycle while results are taken; an accepted item passes two
// front stages, the queue, the divider stages (one quotient bit each), a
// rounding stage and the output register. A stalled result halts the back
// part, the four-entry queue fills, and input ready drops.
// Depends on aftp_pkg, aftp_front, aftp_queue, aftp_back, aftp_out.
`include "affine_from_three_point_pairs_unit_defines.svh"
module affine_from_three_point_pairs_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [aftp_pkg::IN_COORD_BITS-1:0] req_corner_a_x, req_corner_a_y,
   input  logic [aftp_pkg::IN_COORD_BITS-1:0] req_corner_b_x, req_corner_b_y,
   input  logic [aftp_pkg::IN_COORD_BITS-1:0] req_corner_c_x, req_corner_c_y,
   input  logic signed [aftp_pkg::SHIFT_BITS-1:0] req_shift_a_x, req_shift_a_y,
   input  logic signed [aftp_pkg::SHIFT_BITS-1:0] req_shift_b_x, req_shift_b_y,
   input  logic signed [aftp_pkg::SHIFT_BITS-1:0] req_shift_c_x, req_shift_c_y,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [aftp_pkg::OUT_BITS-1:0] rsp_coef_xx, rsp_coef_xy, rsp_coef_x0,
   output logic signed [aftp_pkg::OUT_BITS-1:0] rsp_coef_yx, rsp_coef_yy, rsp_coef_y0,
   output logic rsp_singular,
   output logic rsp_saturated
);
   import aftp_pkg::*;
   logic f_valid, q_empty, b_valid, o_ready, b_adv, f_adv, pop;
   logic [QUEUE_PTR_BITS:0] q_count;
   job_type f_job, q_job;
   logic [NUM_COEF-1:0][OUT_BITS-1:0] b_coef, o_coef;
   logic b_sing, b_sat;

   // Front keeps room: at most two items in flight plus queue contents.
   assign f_adv = 1'b1;
   assign req_ready = (q_count + (QUEUE_PTR_BITS+1)'(2)) < (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH)
                      || (q_count == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH-2) && pop);

   aftp_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_valid && req_ready),
      .ax(req_corner_a_x[COORD_BITS-1:0]), .ay(req_corner_a_y[COORD_BITS-1:0]),
      .bx(req_corner_b_x[COORD_BITS-1:0]), .by(req_corner_b_y[COORD_BITS-1:0]),
      .cx(req_corner_c_x[COORD_BITS-1:0]), .cy(req_corner_c_y[COORD_BITS-1:0]),
      .sax(req_shift_a_x), .say(req_shift_a_y), .sbx(req_shift_b_x),
      .sby(req_shift_b_y), .scx(req_shift_c_x), .scy(req_shift_c_y),
      .advance(f_adv), .out_valid(f_valid), .out_job(f_job)
   );

   assign b_adv = o_ready;
   assign pop = b_adv && !q_empty;

   aftp_queue u_queue (
      .clock(clock), .reset(reset), .push(f_valid), .push_job(f_job),
      .pop(pop), .empty(q_empty), .count(q_count), .pop_job(q_job)
   );

   aftp_back u_back (
      .clock(clock), .reset(reset), .in_valid(pop), .in_job(q_job),
      .advance(b_adv), .out_valid(b_valid), .out_coef(b_coef),
      .out_singular(b_sing), .out_saturated(b_sat)
   );

   aftp_out u_out (
      .clock(clock), .reset(reset), .in_valid(b_valid), .in_coef(b_coef),
      .in_singular(b_sing), .in_saturated(b_sat), .in_ready(o_ready),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_coef(o_coef),
      .out_singular(rsp_singular), .out_saturated(rsp_saturated)
   );

   assign rsp_coef_xx = o_coef[0];
   assign rsp_coef_xy = o_coef[1];
   assign rsp_coef_x0 = o_coef[2];
   assign rsp_coef_yx = o_coef[3];
   assign rsp_coef_yy = o_coef[4];
   assign rsp_coef_y0 = o_coef[5];

   `AFTP_ASSERT_IMP(a_no_overflow, clock, reset, q_count == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH), !f_valid || pop)
   `AFTP_ASSERT_IMP(a_sing_zero, clock, reset, rsp_valid && rsp_singular, rsp_coef_xx == '0 && !rsp_saturated)
   `AFTP_ASSERT_NEXT(a_pop_nonempty, clock, reset, q_empty && !f_valid, !pop || q_count != '0)
endmodule

// File: hdl/aftp_front.sv
// Front part: forms the determinant and the six numerators of one item.
// Depends on aftp_pkg. Two register stages.
module aftp_front (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic [aftp_pkg::COORD_BITS-1:0] ax, ay, bx, by, cx, cy,
   input  logic signed [aftp_pkg::SHIFT_BITS-1:0] sax, say, sbx, sby, scx, scy,
   input  logic advance,
   output logic out_valid,
   output aftp_pkg::job_type out_job
);
   import aftp_pkg::*;
   logic v1_ff, v2_ff;
   logic signed [DIFF_BITS-1:0] e1, f1, e2, f2;
   logic signed [DET_BITS-1:0] det_in, det_ff, det2_ff;
   logic signed [1:0][NUM_BITS-1:0] n0_in, n1_in, n0_ff, n1_ff;
   logic signed [1:0][U_BITS-1:0] ua_in, ua_ff;
   logic signed [DIFF_BITS:0] pax_ff, pay_ff;
   logic [NUM_COEF-1:0][CON_BITS-1:0] num_ff;

   always_comb begin
      e1 = $signed({1'b0, bx}) - $signed({1'b0, ax});
      f1 = $signed({1'b0, by}) - $signed({1'b0, ay});
      e2 = $signed({1'b0, cx}) - $signed({1'b0, ax});
      f2 = $signed({1'b0, cy}) - $signed({1'b0, ay});
      det_in = DET_BITS'(e1 * f2) - DET_BITS'(e2 * f1);
      for (int k = 0; k < 2; k++) begin
         logic signed [U_BITS-1:0] ub, uc;
         logic signed [G_BITS-1:0] g1, g2;
         ua_in[k] = U_BITS'($signed({1'b0, k == 0 ? ax : ay}))
                  + U_BITS'(k == 0 ? sax : say);
         ub = U_BITS'($signed({1'b0, k == 0 ? bx : by})) + U_BITS'(k == 0 ? sbx : sby);
         uc = U_BITS'($signed({1'b0, k == 0 ? cx : cy})) + U_BITS'(k == 0 ? scx : scy);
         g1 = G_BITS'(ub) - G_BITS'($signed(ua_in[k]));
         g2 = G_BITS'(uc) - G_BITS'($signed(ua_in[k]));
         n0_in[k] = NUM_BITS'(g1 * f2) - NUM_BITS'(g2 * f1);
         n1_in[k] = NUM_BITS'(e1 * g2) - NUM_BITS'(e2 * g1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (advance) begin
         det_ff <= det_in;
         n0_ff <= n0_in;
         n1_ff <= n1_in;
         ua_ff <= ua_in;
         pax_ff <= $signed({2'b0, ax});
         pay_ff <= $signed({2'b0, ay});
         det2_ff <= det_ff;
         for (int k = 0; k < 2; k++) begin
            num_ff[3*k] <= CON_BITS'($signed(n0_ff[k]));
            num_ff[3*k+1] <= CON_BITS'($signed(n1_ff[k]));
            num_ff[3*k+2] <= CON_BITS'($signed(ua_ff[k]) * det_ff)
                           - CON_BITS'($signed(n0_ff[k]) * pax_ff)
                           - CON_BITS'($signed(n1_ff[k]) * pay_ff);
         end
      end
   end

   always_comb begin
      out_job.det = det2_ff;
      out_job.num = num_ff;
   end
   assign out_valid = v2_ff;
endmodule

// File: hdl/aftp_queue.sv
// Short queue between the front and back parts.
// Depends on aftp_pkg.
module aftp_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  aftp_pkg::job_type push_job,
   input  logic pop,
   output logic empty,
   output logic [aftp_pkg::QUEUE_PTR_BITS:0] count,
   output aftp_pkg::job_type pop_job
);
   import aftp_pkg::*;
   job_type mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ff, rd_ff;
   logic [QUEUE_PTR_BITS:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (QUEUE_PTR_BITS+1)'(push) - (QUEUE_PTR_BITS+1)'(pop);
      end
      if (push) mem_ff[wr_ff] <= push_job;
   end
   assign pop_job = mem_ff[rd_ff];
   assign empty = cnt_ff == '0;
   assign count = cnt_ff;
endmodule

// File: hdl/aftp_back.sv
// Back part: pipelined restoring divider, one quotient bit per stage,
// six lanes, then rounding and clipping. Depends on aftp_pkg.
module aftp_back (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  aftp_pkg::job_type in_job,
   input  logic advance,
   output logic out_valid,
   output logic signed [aftp_pkg::NUM_COEF-1:0][aftp_pkg::OUT_BITS-1:0] out_coef,
   output logic out_singular,
   output logic out_saturated
);
   import aftp_pkg::*;
   localparam int S = DIV_STEPS;
   localparam int R_BITS = DET_BITS;

   logic [S:0] v_ff;
   logic [S:0][DET_BITS-1:0] dm_ff;
   logic [S:0] sing_ff;
   logic [S:0][NUM_COEF-1:0] neg_ff, big_ff;
   logic [S:0][NUM_COEF-1:0][DIV_STEPS-1:0] n_ff;
   logic [S:0][NUM_COEF-1:0][R_BITS-1:0] r_ff;
   logic [S:0][NUM_COEF-1:0][QUO_BITS-1:0] q_ff;
   logic [NUM_COEF-1:0][OUT_BITS-1:0] res_ff;
   logic sing_o_ff, sat_ff, vo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
         vo_ff <= 1'b0;
      end else if (advance) begin
         v_ff <= {v_ff[S-1:0], in_valid};
         vo_ff <= v_ff[S];
      end
      if (advance) begin
         dm_ff[0] <= in_job.det[DET_BITS-1] ? DET_BITS'(-in_job.det) : in_job.det;
         sing_ff[0] <= in_job.det == '0;
         for (int c = 0; c < NUM_COEF; c++) begin
            logic [CON_BITS-1:0] mag;
            mag = in_job.num[c][CON_BITS-1] ? CON_BITS'(-in_job.num[c]) : in_job.num[c];
            neg_ff[0][c] <= in_job.num[c][CON_BITS-1] ^ in_job.det[DET_BITS-1];
            n_ff[0][c] <= {mag, {FRAC_BITS{1'b0}}};
            r_ff[0][c] <= '0;
            q_ff[0][c] <= '0;
            big_ff[0][c] <= 1'b0;
         end
         for (int s = 0; s < S; s++) begin
            dm_ff[s+1] <= dm_ff[s];
            sing_ff[s+1] <= sing_ff[s];
            neg_ff[s+1] <= neg_ff[s];
            for (int c = 0; c < NUM_COEF; c++) begin
               logic [R_BITS:0] rr;
               logic qb;
               rr = {r_ff[s][c], n_ff[s][c][DIV_STEPS-1]};
               qb = rr >= {1'b0, dm_ff[s]};
               if (qb) rr = rr - {1'b0, dm_ff[s]};
               r_ff[s+1][c] <= rr[R_BITS-1:0];
               n_ff[s+1][c] <= {n_ff[s][c][DIV_STEPS-2:0], 1'b0};
               q_ff[s+1][c] <= big_ff[s][c] ? q_ff[s][c] : {q_ff[s][c][QUO_BITS-2:0], qb};
               big_ff[s+1][c] <= big_ff[s][c] | q_ff[s][c][QUO_BITS-2]
                               | (q_ff[s][c][QUO_BITS-2:0] == '1 && qb);
            end
         end
         sing_o_ff <= sing_ff[S];
         begin
            logic sat;
            sat = 1'b0;
            for (int c = 0; c < NUM_COEF; c++) begin
               logic [QUO_BITS:0] qr;
               logic [QUO_BITS:0] lim;
               logic big;
               big = big_ff[S][c] | q_ff[S][c][QUO_BITS-1];
               qr = {1'b0, q_ff[S][c]} +
                    (QUO_BITS+1)'(!big && ({r_ff[S][c], 1'b0} >= {1'b0, dm_ff[S]}));
               lim = neg_ff[S][c] ? (QUO_BITS+1)'(1) << (OUT_BITS-1)
                                 : ((QUO_BITS+1)'(1) << (OUT_BITS-1)) - 1'b1;
               if (big || qr > lim) begin
                  qr = lim;
                  sat = 1'b1;
               end
               if (neg_ff[S][c]) qr = -qr;
               res_ff[c] <= sing_ff[S] ? '0 : qr[OUT_BITS-1:0];
            end
            sat_ff <= sat & ~sing_ff[S];
         end
      end
   end

   assign out_valid = vo_ff;
   assign out_coef = res_ff;
   assign out_singular = sing_o_ff;
   assign out_saturated = sat_ff;
endmodule

// File: hdl/aftp_out.sv
// Output skid register holding one finished item for the consumer.
// Depends on aftp_pkg.
module aftp_out (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic signed [aftp_pkg::NUM_COEF-1:0][aftp_pkg::OUT_BITS-1:0] in_coef,
   input  logic in_singular,
   input  logic in_saturated,
   output logic in_ready,
   output logic out_valid,
   input  logic out_ready,
   output logic signed [aftp_pkg::NUM_COEF-1:0][aftp_pkg::OUT_BITS-1:0] out_coef,
   output logic out_singular,
   output logic out_saturated
);
   import aftp_pkg::*;
   logic v_ff;
   logic [NUM_COEF-1:0][OUT_BITS-1:0] c_ff;
   logic s_ff, t_ff;
   assign in_ready = !v_ff || out_ready;
   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else if (in_ready) v_ff <= in_valid;
      if (in_ready && in_valid) begin
         c_ff <= in_coef;
         s_ff <= in_singular;
         t_ff <= in_saturated;
      end
   end
   assign out_valid = v_ff;
   assign out_coef = c_ff;
   assign out_singular = s_ff;
   assign out_saturated = t_ff;
endmodule
